FILE: hw/rtl/md5_pkg.sv
// Shared types, constants and round functions of the MD5 digest engine.
// Used by md5_blkbuf, md5_byte_stream_digest and the testbench; depends on nothing.
package md5_pkg;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [7:0]  PAD_MARK = 8'h80;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned LEN_LIMIT = 55;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD
  } md5_state_t;

  // Padding view of the block that is being compressed.
  typedef struct packed {
    logic [6:0] len;
    logic       mark;
    logic       len_words;
  } blk_ctrl_t;

  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] lo;
    lo = r[3:0];
    case (r[5:4])
      2'd0:    msg_index = lo;
      2'd1:    msg_index = lo * 4'd5 + 4'd1;
      2'd2:    msg_index = lo * 4'd3 + 4'd5;
      default: msg_index = lo * 4'd7;
    endcase
  endfunction

  function automatic logic [31:0] round_f(input logic [5:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    case (r[5:4])
      2'd0:    round_f = (b & c) | (~b & d);
      2'd1:    round_f = (b & d) | (c & ~d);
      2'd2:    round_f = b ^ c ^ d;
      default: round_f = c ^ (b | ~d);
    endcase
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    case ({r[5:4], r[1:0]})
      4'd0:    rot_amount = 5'd7;
      4'd1:    rot_amount = 5'd12;
      4'd2:    rot_amount = 5'd17;
      4'd3:    rot_amount = 5'd22;
      4'd4:    rot_amount = 5'd5;
      4'd5:    rot_amount = 5'd9;
      4'd6:    rot_amount = 5'd14;
      4'd7:    rot_amount = 5'd20;
      4'd8:    rot_amount = 5'd4;
      4'd9:    rot_amount = 5'd11;
      4'd10:   rot_amount = 5'd16;
      4'd11:   rot_amount = 5'd23;
      4'd12:   rot_amount = 5'd6;
      4'd13:   rot_amount = 5'd10;
      4'd14:   rot_amount = 5'd15;
      default: rot_amount = 5'd21;
    endcase
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] t;
    t = {v, v} << n;
    rotl32 = t[63:32];
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    case (r)
      6'd0:  round_k = 32'hd76aa478;  6'd1:  round_k = 32'he8c7b756;
      6'd2:  round_k = 32'h242070db;  6'd3:  round_k = 32'hc1bdceee;
      6'd4:  round_k = 32'hf57c0faf;  6'd5:  round_k = 32'h4787c62a;
      6'd6:  round_k = 32'ha8304613;  6'd7:  round_k = 32'hfd469501;
      6'd8:  round_k = 32'h698098d8;  6'd9:  round_k = 32'h8b44f7af;
      6'd10: round_k = 32'hffff5bb1;  6'd11: round_k = 32'h895cd7be;
      6'd12: round_k = 32'h6b901122;  6'd13: round_k = 32'hfd987193;
      6'd14: round_k = 32'ha679438e;  6'd15: round_k = 32'h49b40821;
      6'd16: round_k = 32'hf61e2562;  6'd17: round_k = 32'hc040b340;
      6'd18: round_k = 32'h265e5a51;  6'd19: round_k = 32'he9b6c7aa;
      6'd20: round_k = 32'hd62f105d;  6'd21: round_k = 32'h02441453;
      6'd22: round_k = 32'hd8a1e681;  6'd23: round_k = 32'he7d3fbc8;
      6'd24: round_k = 32'h21e1cde6;  6'd25: round_k = 32'hc33707d6;
      6'd26: round_k = 32'hf4d50d87;  6'd27: round_k = 32'h455a14ed;
      6'd28: round_k = 32'ha9e3e905;  6'd29: round_k = 32'hfcefa3f8;
      6'd30: round_k = 32'h676f02d9;  6'd31: round_k = 32'h8d2a4c8a;
      6'd32: round_k = 32'hfffa3942;  6'd33: round_k = 32'h8771f681;
      6'd34: round_k = 32'h6d9d6122;  6'd35: round_k = 32'hfde5380c;
      6'd36: round_k = 32'ha4beea44;  6'd37: round_k = 32'h4bdecfa9;
      6'd38: round_k = 32'hf6bb4b60;  6'd39: round_k = 32'hbebfbc70;
      6'd40: round_k = 32'h289b7ec6;  6'd41: round_k = 32'heaa127fa;
      6'd42: round_k = 32'hd4ef3085;  6'd43: round_k = 32'h04881d05;
      6'd44: round_k = 32'hd9d4d039;  6'd45: round_k = 32'he6db99e5;
      6'd46: round_k = 32'h1fa27cf8;  6'd47: round_k = 32'hc4ac5665;
      6'd48: round_k = 32'hf4292244;  6'd49: round_k = 32'h432aff97;
      6'd50: round_k = 32'hab9423a7;  6'd51: round_k = 32'hfc93a039;
      6'd52: round_k = 32'h655b59c3;  6'd53: round_k = 32'h8f0ccc92;
      6'd54: round_k = 32'hffeff47d;  6'd55: round_k = 32'h85845dd1;
      6'd56: round_k = 32'h6fa87e4f;  6'd57: round_k = 32'hfe2ce6e0;
      6'd58: round_k = 32'ha3014314;  6'd59: round_k = 32'h4e0811a1;
      6'd60: round_k = 32'hf7537e82;  6'd61: round_k = 32'hbd3af235;
      6'd62: round_k = 32'h2ad7d2bb;  default: round_k = 32'heb86d391;
    endcase
  endfunction

endpackage

FILE: hw/rtl/md5_if.sv
// Valid/ready channel interfaces of the MD5 digest engine.
// One carries message bytes in, the other carries digests out; no dependencies.
interface md5_msg_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface md5_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word_a;
  logic [31:0] digest_word_b;
  logic [31:0] digest_word_c;
  logic [31:0] digest_word_d;

  modport source (output valid, output digest_word_a, output digest_word_b,
                  output digest_word_c, output digest_word_d, input ready);
  modport sink (input valid, input digest_word_a, input digest_word_b,
                input digest_word_c, input digest_word_d, output ready);
endinterface

FILE: hw/rtl/md5_blkbuf.sv
// Block buffer of the MD5 engine: a 16 x 32 bit memory written one byte at a time,
// read one word per cycle with the message padding applied. Depends on md5_pkg.
module md5_blkbuf (
  input  logic               clk,
  input  logic               we,
  input  logic [5:0]         waddr,
  input  logic [7:0]         wdata,
  input  logic [3:0]         raddr,
  input  md5_pkg::blk_ctrl_t ctrl,
  input  logic [63:0]        bit_len,
  output logic [31:0]        word
);
  import md5_pkg::*;

  logic [31:0] mem [BLOCK_WORDS];
  logic [31:0] rdata;
  logic [3:0]  rg;
  logic [6:0]  idx [4];
  logic [31:0] padded;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[5:2]][8*waddr[1:0] +: 8] <= wdata;
    end
    rdata <= mem[raddr];
    rg <= raddr;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      idx[i] = {1'b0, rg, 2'(i)};
      if (idx[i] < ctrl.len) begin
        padded[8*i +: 8] = rdata[8*i +: 8];
      end else if (ctrl.mark && idx[i] == ctrl.len) begin
        padded[8*i +: 8] = PAD_MARK;
      end else begin
        padded[8*i +: 8] = 8'h00;
      end
    end
    if (ctrl.len_words && rg == 4'd14) begin
      word = bit_len[31:0];
    end else if (ctrl.len_words && rg == 4'd15) begin
      word = bit_len[63:32];
    end else begin
      word = padded;
    end
  end

endmodule

FILE: hw/rtl/md5_byte_stream_digest.sv
// MD5 digest engine taking one message byte per word. A data byte is accepted while idle;
// the byte that fills a 64-byte block starts a compression (a load step, 64 rounds on
// the single round unit, a fold step) during which no word is accepted. A finish word
// starts one such compression, or two when the padding spills into a second block, and
// its last fold waits for the previous digest to be taken. Depends on md5_pkg, md5_if, md5_blkbuf.
module md5_byte_stream_digest (
  input logic         clk,
  input logic         rst,
  md5_msg_if.sink     msg,
  md5_digest_if.source digest
);
  import md5_pkg::*;

  md5_state_t  state, state_next;
  logic [5:0]  round;
  logic [31:0] chain_a, chain_b, chain_c, chain_d;
  logic [31:0] wa, wb, wc, wd;
  logic [5:0]  off;
  logic [63:0] byte_count;
  blk_ctrl_t   ctrl;
  logic        blk_final, blk_more;
  logic        out_valid;
  logic [31:0] dig_a, dig_b, dig_c, dig_d;

  logic        msg_acc;
  logic [3:0]  raddr;
  logic [31:0] word;
  logic [31:0] sum, new_b;
  logic [31:0] fa, fb, fc, fd;
  logic        slot_free;

  assign msg.ready = (state == ST_IDLE);
  assign msg_acc = msg.valid && msg.ready;
  assign raddr = (state == ST_ROUND) ? msg_index(round + 6'd1) : msg_index(6'd0);

  md5_blkbuf u_buf (
    .clk     (clk),
    .we      (msg_acc && msg.kind == KIND_DATA),
    .waddr   (off),
    .wdata   (msg.data_byte),
    .raddr   (raddr),
    .ctrl    (ctrl),
    .bit_len ({byte_count[60:0], 3'b000}),
    .word    (word)
  );

  assign sum = round_f(round, wb, wc, wd) + wa + round_k(round) + word;
  assign new_b = wb + rotl32(sum, rot_amount(round));
  assign fa = chain_a + wa;
  assign fb = chain_b + wb;
  assign fc = chain_c + wc;
  assign fd = chain_d + wd;
  assign slot_free = !out_valid || digest.ready;

  assign digest.valid = out_valid;
  assign digest.digest_word_a = dig_a;
  assign digest.digest_word_b = dig_b;
  assign digest.digest_word_c = dig_c;
  assign digest.digest_word_d = dig_d;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (msg_acc && (msg.kind == KIND_FINISH || off == 6'd63)) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: state_next = ST_ROUND;
      ST_ROUND: begin
        if (round == 6'd63) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (blk_more) begin
          state_next = ST_LOAD;
        end else if (!blk_final || slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round <= 6'd0;
      off <= 6'd0;
      byte_count <= 64'd0;
      chain_a <= INIT_A;
      chain_b <= INIT_B;
      chain_c <= INIT_C;
      chain_d <= INIT_D;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && digest.ready && !(state == ST_FOLD && !blk_more && blk_final)) begin
        out_valid <= 1'b0;
      end
      if (msg_acc && msg.kind == KIND_DATA) begin
        off <= off + 6'd1;
        byte_count <= byte_count + 64'd1;
      end
      if (state == ST_LOAD) begin
        round <= 6'd0;
      end else if (state == ST_ROUND) begin
        round <= round + 6'd1;
      end
      if (state == ST_FOLD) begin
        if (blk_more || !blk_final) begin
          chain_a <= fa;
          chain_b <= fb;
          chain_c <= fc;
          chain_d <= fd;
        end else if (slot_free) begin
          out_valid <= 1'b1;
          chain_a <= INIT_A;
          chain_b <= INIT_B;
          chain_c <= INIT_C;
          chain_d <= INIT_D;
          off <= 6'd0;
          byte_count <= 64'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (msg_acc) begin
      if (msg.kind == KIND_DATA) begin
        ctrl <= '{len: 7'(BLOCK_BYTES), mark: 1'b0, len_words: 1'b0};
        blk_final <= 1'b0;
        blk_more <= 1'b0;
      end else begin
        ctrl <= '{len: {1'b0, off}, mark: 1'b1, len_words: (off <= 6'(LEN_LIMIT))};
        blk_final <= (off <= 6'(LEN_LIMIT));
        blk_more <= (off > 6'(LEN_LIMIT));
      end
    end
    if (state == ST_LOAD) begin
      wa <= chain_a;
      wb <= chain_b;
      wc <= chain_c;
      wd <= chain_d;
    end else if (state == ST_ROUND) begin
      wa <= wd;
      wd <= wc;
      wc <= wb;
      wb <= new_b;
    end
    if (state == ST_FOLD && blk_more) begin
      ctrl <= '{len: 7'd0, mark: 1'b0, len_words: 1'b1};
      blk_more <= 1'b0;
      blk_final <= 1'b1;
    end
    if (state == ST_FOLD && !blk_more && blk_final && slot_free) begin
      dig_a <= fa;
      dig_b <= fb;
      dig_c <= fc;
      dig_d <= fd;
    end
  end

  a_rose_from_fold: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FOLD))
    else $error("digest appeared without a final fold");

  a_restart_on_digest: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (off == 6'd0 && byte_count == 64'd0 && chain_a == INIT_A))
    else $error("engine did not restart after a digest");

  a_load_then_round0: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |=> (state == ST_ROUND && round == 6'd0))
    else $error("compression did not start at round zero");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND || state == ST_FOLD) |-> !msg.ready)
    else $error("word accepted during compression");

  a_fold_after_last_round: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && round == 6'd63) |=> (state == ST_FOLD))
    else $error("compression did not end after the last round");

endmodule

FILE: tb/sv/md5_digest_checker.sv
// Checker for the MD5 byte-stream digest engine: watches the message and digest channels,
// predicts every digest in its own MD5 model and compares the words field by field.
// Depends on md5_pkg and the channel interfaces in md5_if.
module md5_digest_checker (
  input  logic         clk,
  input  logic         rst,
  md5_msg_if           msg,
  md5_digest_if        digest,
  output int           failures,
  output int           pending,
  output int           digests_checked,
  output int           bytes_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import md5_pkg::*;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } digest_words_t;

  localparam logic [31:0] SINE_ADD [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int unsigned SHIFT_BY [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  logic [31:0]   chain [4];
  logic [7:0]    msg_block [64];
  int unsigned   fill;
  logic [63:0]   msg_len;
  digest_words_t expected_digests [$];

  function automatic void restart_chain();
    chain[0] = INIT_A;
    chain[1] = INIT_B;
    chain[2] = INIT_C;
    chain[3] = INIT_D;
    fill = 0;
    msg_len = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, sum;
    int unsigned g, n;
    for (int unsigned i = 0; i < 16; i++) begin
      w[i] = {msg_block[4*i+3], msg_block[4*i+2], msg_block[4*i+1], msg_block[4*i]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (int unsigned r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      sum = f + a + SINE_ADD[r] + w[g];
      n = SHIFT_BY[(r / 16) * 4 + (r % 4)];
      a = d;
      d = c;
      c = b;
      b = b + ((sum << n) | (sum >> (32 - n)));
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
  endfunction

  function automatic void absorb_byte(input logic [7:0] value);
    msg_block[fill] = value;
    msg_len = msg_len + 64'd1;
    fill++;
    if (fill == BLOCK_BYTES) begin
      compress_block();
      fill = 0;
    end
  endfunction

  function automatic void close_message();
    logic [63:0] bit_len;
    msg_block[fill] = PAD_MARK;
    fill++;
    if (fill > 56) begin
      for (int unsigned i = fill; i < 64; i++) msg_block[i] = 8'h00;
      compress_block();
      fill = 0;
    end
    for (int unsigned i = fill; i < 56; i++) msg_block[i] = 8'h00;
    bit_len = msg_len << 3;
    for (int unsigned k = 0; k < 8; k++) msg_block[56 + k] = bit_len[8*k +: 8];
    compress_block();
    expected_digests.push_back('{chain[0], chain[1], chain[2], chain[3]});
    restart_chain();
  endfunction

  always @(posedge clk) begin
    digest_words_t want;
    if (rst) begin
      restart_chain();
      expected_digests.delete();
      failures <= 0;
      digests_checked <= 0;
      bytes_seen <= 0;
    end else begin
      if (msg.valid && msg.ready) begin
        if (msg.kind == KIND_FINISH) begin
          close_message();
        end else begin
          absorb_byte(msg.data_byte);
          bytes_seen <= bytes_seen + 1;
        end
      end
      if (digest.valid && digest.ready) begin
        if (expected_digests.size() == 0) begin
          $error("Digest word %h %h %h %h arrived with no message finished.",
                 digest.digest_word_a, digest.digest_word_b,
                 digest.digest_word_c, digest.digest_word_d);
          failures <= failures + 1;
        end else begin
          want = expected_digests.pop_front();
          digests_checked <= digests_checked + 1;
          if (digest.digest_word_a !== want.a || digest.digest_word_b !== want.b ||
              digest.digest_word_c !== want.c || digest.digest_word_d !== want.d) begin
            failures <= failures + 1;
          end
          if (digest.digest_word_a !== want.a)
            $error("digest_word_a: expected %h, got %h", want.a, digest.digest_word_a);
          if (digest.digest_word_b !== want.b)
            $error("digest_word_b: expected %h, got %h", want.b, digest.digest_word_b);
          if (digest.digest_word_c !== want.c)
            $error("digest_word_c: expected %h, got %h", want.c, digest.digest_word_c);
          if (digest.digest_word_d !== want.d)
            $error("digest_word_d: expected %h, got %h", want.d, digest.digest_word_d);
        end
      end
    end
    pending <= expected_digests.size();
  end

endmodule

FILE: tb/sv/md5_byte_stream_digest_tb.sv
// Top of the MD5 byte-stream digest testbench: clock, reset, message stimulus with random
// idling and a long receiver hold-off, and the verdict. Depends on md5_pkg, md5_if,
// md5_byte_stream_digest and md5_digest_checker.
module md5_byte_stream_digest_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import md5_pkg::*;

  logic clk;
  logic rst;
  bit   steady;
  bit   hold_request;
  bit   hold_done;
  int   words_sent;
  int   messages_sent;
  int   failures;
  int   pending;
  int   digests_checked;
  int   bytes_seen;

  md5_msg_if    msg_ch ();
  md5_digest_if digest_ch ();

  md5_byte_stream_digest i_dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .digest (digest_ch)
  );

  md5_digest_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .msg             (msg_ch),
    .digest          (digest_ch),
    .failures        (failures),
    .pending         (pending),
    .digests_checked (digests_checked),
    .bytes_seen      (bytes_seen)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // Digest receiver: random stalls, plus one long hold-off on request.
  initial begin
    digest_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        digest_ch.ready = 1'b0;
        repeat (800) @(negedge clk);
        hold_done = 1'b1;
      end
      digest_ch.ready = steady || ($urandom_range(99) >= 20);
    end
  end

  task automatic put_word(input logic kind, input logic [7:0] value);
    if (!steady && $urandom_range(99) < 20) begin
      msg_ch.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    msg_ch.valid = 1'b1;
    msg_ch.kind = kind;
    msg_ch.data_byte = value;
    do @(posedge clk); while (!msg_ch.ready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) put_word(KIND_DATA, 8'($urandom));
    put_word(KIND_FINISH, 8'($urandom));
    messages_sent++;
  endtask

  function automatic int unsigned pick_length();
    case ($urandom_range(9))
      0, 1, 2: pick_length = $urandom_range(0, 20);
      3:       pick_length = $urandom_range(0, 63);
      4, 5:    pick_length = $urandom_range(50, 70);
      6:       pick_length = $urandom_range(53, 58);
      7:       pick_length = $urandom_range(115, 135);
      default: pick_length = $urandom_range(1) ? 64 * $urandom_range(1, 4)
                                                : $urandom_range(150, 260);
    endcase
  endfunction

  initial begin
    rst = 1'b1;
    msg_ch.valid = 1'b0;
    msg_ch.kind = KIND_DATA;
    msg_ch.data_byte = 8'h00;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty message with a nonzero ignored byte, then back-to-back finishes and three short messages.
    put_word(KIND_FINISH, 8'hff);
    put_word(KIND_FINISH, 8'h00);
    put_word(KIND_DATA, "a");
    put_word(KIND_FINISH, 8'h5a);
    put_word(KIND_DATA, "a");
    put_word(KIND_DATA, "b");
    put_word(KIND_DATA, "c");
    put_word(KIND_FINISH, 8'h00);
    put_word(KIND_DATA, 8'h00);
    put_word(KIND_DATA, 8'hff);
    put_word(KIND_DATA, PAD_MARK);
    put_word(KIND_DATA, 8'h7f);
    put_word(KIND_FINISH, 8'hff);
    messages_sent += 5;

    while (words_sent < 2000) begin
      steady = (words_sent >= 200 && words_sent < 500);
      if (words_sent >= 900 && !hold_request) begin
        hold_request = 1'b1;
        repeat (6) send_message($urandom_range(0, 8));
      end else begin
        send_message(pick_length());
      end
    end
    steady = 1'b0;
    msg_ch.valid = 1'b0;

    wait (pending == 0);
    repeat (150) @(posedge clk);
    $display("Sent %0d words: %0d messages holding %0d bytes; %0d digests compared.",
             words_sent, messages_sent, bytes_seen, digests_checked);
    $display("Lengths spanned the padding boundaries, and the receiver held off once.");
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
